@@ hw/rtl/frl_pkg.sv @@
// Package for the Fresnel reflectance block: formats, constants and side-band type.
`default_nettype none
package frl_pkg;

  // Fixed-point units
  localparam logic [15:0] OneQ12  = 16'd4096;
  localparam logic [30:0] OneQ30  = 31'h4000_0000;
  localparam logic [28:0] OneQ28  = 29'h1000_0000;
  localparam logic [15:0] OneQ15  = 16'd32768;

  // Quantities that travel alongside the iterative units
  typedef struct packed {
    logic        tir;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } frl_side_t;

endpackage
`default_nettype wire

@@ hw/rtl/fresnel_reflectance.sv @@
// Top level: unpolarized Fresnel reflectance of a dielectric interface.
//
// Input channel (in_valid / in_stall) takes an incident direction and a
// surface normal (signed Q1.14) and a refraction index (unsigned Q4.12).
// Output channel (out_valid / out_stall) returns one reflectance (Q1.15)
// and a total-internal-reflection flag for every input transfer, in order.
// The pipeline has four front stages (products, clamp, squares,
// sin^2 scaling), 30 stages of the sin^2 t divider, 16 stages of the
// square root, one product stage, 17 stages of the two ratio dividers,
// one squaring stage and the output register.
// Throughput is one transfer per cycle. The whole pipeline moves as one:
// while the output register holds a result that the receiver stalls, every
// stage holds and in_stall is raised, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; no result is shown until new
// transfers arrive. There is no configuration and no state between items.
`default_nettype none
module fresnel_reflectance
  import frl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] incident_x,
  input  wire logic [15:0] incident_y,
  input  wire logic [15:0] incident_z,
  input  wire logic [15:0] normal_x,
  input  wire logic [15:0] normal_y,
  input  wire logic [15:0] normal_z,
  input  wire logic [15:0] refr_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      reflectance,
  output logic             total_internal
);

  logic adv;

  // Pipeline advances when the output register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: component products
  logic               vld1;
  logic signed [31:0] px, py, pz;
  logic [15:0]        n1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv) begin
      vld1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= $signed(incident_x) * $signed(normal_x);
      py <= $signed(incident_y) * $signed(normal_y);
      pz <= $signed(incident_z) * $signed(normal_z);
      n1 <= refr_index;
    end
  end

  // Stage 2: dot product, clamp, cosine and index order
  logic               vld2;
  logic [15:0]        a2, b2, c2;
  logic signed [33:0] dot;
  logic signed [33:0] dot_cl;
  logic [28:0]        mag;
  logic [29:0]        mag_rnd;
  logic [15:0]        n_fix;
  logic [15:0]        a_next, b_next, c_next;

  always_comb begin
    dot = 34'(px) + 34'(py) + 34'(pz);
    if (dot > $signed({5'b0, OneQ28})) begin
      dot_cl = $signed({5'b0, OneQ28});
    end else if (dot < -$signed({5'b0, OneQ28})) begin
      dot_cl = -$signed({5'b0, OneQ28});
    end else begin
      dot_cl = dot;
    end
    mag     = (dot_cl < 0) ? 29'(-dot_cl) : 29'(dot_cl);
    mag_rnd = 30'(mag) + 30'd4096;
    c_next  = 16'(mag_rnd >> 13);
    n_fix   = (n1 == 16'd0) ? 16'd1 : n1;
    // Leaving the material swaps the indices
    if (dot_cl > 0) begin
      a_next = n_fix;
      b_next = OneQ12;
    end else begin
      a_next = OneQ12;
      b_next = n_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2 <= a_next;
      b2 <= b_next;
      c2 <= c_next;
    end
  end

  // Stage 3: squares
  logic        vld3;
  logic [15:0] a3, b3, c3;
  logic [30:0] csq3;
  logic [31:0] asq3, bsq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (adv) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      csq3 <= 31'(c2) * 31'(c2);
      asq3 <= 32'(a2) * 32'(a2);
      bsq3 <= 32'(b2) * 32'(b2);
      a3   <= a2;
      b3   <= b2;
      c3   <= c2;
    end
  end

  // Stage 4: sin^2 i scaled by a^2
  logic        vld4;
  logic [15:0] a4, b4, c4;
  logic [62:0] sa2_4;
  logic [31:0] bsq4;
  logic [30:0] sin2;

  assign sin2 = OneQ30 - csq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (adv) begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa2_4 <= 63'(sin2) * 63'(asq3);
      bsq4  <= bsq3;
      a4    <= a3;
      b4    <= b3;
      c4    <= c3;
    end
  end

  // Total reflection test, then sin^2 t = S*a^2 / b^2
  frl_side_t   side4;
  logic        dvld;
  logic [29:0] sin2t;
  frl_side_t   dside;

  always_comb begin
    side4.tir = sa2_4 >= {1'b0, bsq4, 30'b0};
    side4.a   = a4;
    side4.b   = b4;
    side4.c   = c4;
  end

  frl_div_pipe #(
    .NumW (63),
    .DenW (32),
    .QuoW (30),
    .SideW($bits(frl_side_t))
  ) u_div_t (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (vld4),
    .num     (sa2_4),
    .den     (bsq4),
    .side    (side4),
    .out_vld (dvld),
    .quo     (sin2t),
    .out_side(dside)
  );

  // cos t = sqrt(1 - sin^2 t)
  logic [30:0] cos2t;
  logic        svld;
  logic [15:0] ct;
  frl_side_t   sside;

  assign cos2t = OneQ30 - 31'(sin2t);

  frl_sqrt_pipe #(
    .RootW(16),
    .XW   (31),
    .SideW($bits(frl_side_t))
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (dvld),
    .x       (cos2t),
    .side    (dside),
    .out_vld (svld),
    .root    (ct),
    .out_side(sside)
  );

  // Stage 6: cross products of indices and cosines
  logic        vld6, tir6;
  logic [31:0] bc6, act6, ac6, bct6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else if (adv) begin
      vld6 <= svld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bc6  <= 32'(sside.b) * 32'(sside.c);
      act6 <= 32'(sside.a) * 32'(ct);
      ac6  <= 32'(sside.a) * 32'(sside.c);
      bct6 <= 32'(sside.b) * 32'(ct);
      tir6 <= sside.tir;
    end
  end

  // Amplitude ratios, Q.16
  logic [31:0] diff_s, diff_p;
  logic [47:0] num_s, num_p;
  logic [32:0] den_s, den_p;

  always_comb begin
    diff_s = (bc6 >= act6) ? bc6 - act6 : act6 - bc6;
    diff_p = (ac6 >= bct6) ? ac6 - bct6 : bct6 - ac6;
    num_s  = {diff_s, 16'b0};
    num_p  = {diff_p, 16'b0};
    den_s  = 33'(bc6) + 33'(act6);
    den_p  = 33'(ac6) + 33'(bct6);
  end

  logic        rs_vld, rp_vld, rs_tir, rp_tir;
  logic [16:0] rs, rp;

  frl_div_pipe #(
    .NumW (48),
    .DenW (33),
    .QuoW (17),
    .SideW(1)
  ) u_div_s (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (vld6),
    .num     (num_s),
    .den     (den_s),
    .side    (tir6),
    .out_vld (rs_vld),
    .quo     (rs),
    .out_side(rs_tir)
  );

  frl_div_pipe #(
    .NumW (48),
    .DenW (33),
    .QuoW (17),
    .SideW(1)
  ) u_div_p (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (vld6),
    .num     (num_p),
    .den     (den_p),
    .side    (tir6),
    .out_vld (rp_vld),
    .quo     (rp),
    .out_side(rp_tir)
  );

  // Stage 8: squared ratios
  logic        vld8, tir8;
  logic [33:0] rs2, rp2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld8 <= 1'b0;
    end else if (adv) begin
      vld8 <= rs_vld & rp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rs2  <= 34'(rs) * 34'(rs);
      rp2  <= 34'(rp) * 34'(rp);
      tir8 <= rs_tir & rp_tir;
    end
  end

  // Output register: mean, rounding and clamp
  logic [34:0] rsum;
  logic [16:0] rmean;
  logic [15:0] refl_next;

  always_comb begin
    rsum  = 35'(rs2) + 35'(rp2) + 35'h2_0000;
    rmean = 17'(rsum >> 18);
    if (tir8 || rmean > 17'(OneQ15)) begin
      refl_next = OneQ15;
    end else begin
      refl_next = rmean[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      reflectance    <= refl_next;
      total_internal <= tir8;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_tir_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && total_internal) |-> (reflectance == OneQ15))
    else $error("total reflection without unit reflectance");

  a_refl_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reflectance <= OneQ15))
    else $error("reflectance above one");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    rs_vld == rp_vld)
    else $error("ratio dividers out of step");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/frl_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module frl_div_pipe #(
  parameter int NumW  = 63,
  parameter int DenW  = 32,
  parameter int QuoW  = 30,
  parameter int SideW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [NumW-1:0]  num,
  input  wire logic [DenW-1:0]  den,
  input  wire logic [SideW-1:0] side,
  output logic                  out_vld,
  output logic [QuoW-1:0]       quo,
  output logic [SideW-1:0]      out_side
);

  localparam int CmpW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  // Index 0 is the input, index i+1 the register of stage i
  logic             vld  [QuoW+1];
  logic [NumW-1:0]  rem  [QuoW+1];
  logic [DenW-1:0]  dens [QuoW+1];
  logic [QuoW-1:0]  qacc [QuoW+1];
  logic [SideW-1:0] sd   [QuoW+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = num;
  assign dens[0] = den;
  assign qacc[0] = '0;
  assign sd[0]   = side;

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    localparam int K = QuoW - 1 - i;
    logic [CmpW-1:0] rem_ext;
    logic [CmpW-1:0] den_sh;
    logic            ge;
    logic [NumW-1:0] rem_next;
    logic [QuoW-1:0] quo_next;

    // Trial subtraction of the shifted divisor
    always_comb begin
      rem_ext  = CmpW'(rem[i]);
      den_sh   = CmpW'(dens[i]) << K;
      ge       = rem_ext >= den_sh;
      rem_next = ge ? NumW'(rem_ext - den_sh) : rem[i];
      quo_next = qacc[i] | (QuoW'(ge) << K);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= rem_next;
        dens[i+1] <= dens[i];
        qacc[i+1] <= quo_next;
        sd[i+1]   <= sd[i];
      end
    end
  end

  assign out_vld  = vld[QuoW];
  assign quo      = qacc[QuoW];
  assign out_side = sd[QuoW];

endmodule
`default_nettype wire

@@ hw/rtl/frl_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per register stage.
`default_nettype none
module frl_sqrt_pipe #(
  parameter int RootW = 16,
  parameter int XW    = 31,
  parameter int SideW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [XW-1:0]    x,
  input  wire logic [SideW-1:0] side,
  output logic                  out_vld,
  output logic [RootW-1:0]      root,
  output logic [SideW-1:0]      out_side
);

  localparam int TW = (XW > 2 * RootW + 2) ? XW : 2 * RootW + 2;

  logic             vld  [RootW+1];
  logic [XW-1:0]    rem  [RootW+1];
  logic [RootW-1:0] racc [RootW+1];
  logic [SideW-1:0] sd   [RootW+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = x;
  assign racc[0] = '0;
  assign sd[0]   = side;

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    localparam int K = RootW - 1 - i;
    logic [TW-1:0]    trial;
    logic [TW-1:0]    rem_ext;
    logic             ge;
    logic [XW-1:0]    rem_next;
    logic [RootW-1:0] root_next;

    // rem holds x - root^2; try setting bit K
    always_comb begin
      trial     = (TW'(racc[i]) << (K + 1)) + (TW'(1) << (2 * K));
      rem_ext   = TW'(rem[i]);
      ge        = rem_ext >= trial;
      rem_next  = ge ? XW'(rem_ext - trial) : rem[i];
      root_next = racc[i] | (RootW'(ge) << K);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= rem_next;
        racc[i+1] <= root_next;
        sd[i+1]   <= sd[i];
      end
    end
  end

  assign out_vld  = vld[RootW];
  assign root     = racc[RootW];
  assign out_side = sd[RootW];

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Testbench for the Fresnel reflectance block: stimulus, predictor and result checks.
`default_nettype wire

// Holds the predicted reflectance results and checks the block's output against them.
class reflectance_board;
  logic [15:0] refl_q[$];
  logic        tir_q[$];
  int          errors;
  int          checked;
  int          tir_seen;

  // Square root rounded down, bit by bit.
  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned amp_ratio(longint unsigned p, longint unsigned q,
                                                longint unsigned d);
    longint unsigned diff;
    diff = (p >= q) ? p - q : q - p;
    return (diff << 16) / d;
  endfunction

  // Note one accepted transfer and work out its reflectance.
  function void note_ray(logic signed [15:0] ix, iy, iz, nx, ny, nz, logic [15:0] idx);
    longint dot;
    longint unsigned mag, c, s, a, b, t, ct, rs, rp, r, n;
    dot = longint'(ix) * nx + longint'(iy) * ny + longint'(iz) * nz;
    if (dot > (64'sd1 <<< 28)) dot = 64'sd1 <<< 28;
    if (dot < -(64'sd1 <<< 28)) dot = -(64'sd1 <<< 28);
    mag = (dot < 0) ? -dot : dot;
    c = (mag + 4096) >> 13;
    n = (idx == 0) ? 1 : idx;
    // leaving the material swaps the indices
    if (dot > 0) begin
      a = n; b = 4096;
    end else begin
      a = 4096; b = n;
    end
    s = (64'd1 << 30) - c * c;
    if (s * a * a >= b * b * (64'd1 << 30)) begin
      refl_q.push_back(16'd32768);
      tir_q.push_back(1'b1);
      return;
    end
    t = (s * a * a) / (b * b);
    ct = isqrt((64'd1 << 30) - t);
    rs = amp_ratio(b * c, a * ct, b * c + a * ct);
    rp = amp_ratio(a * c, b * ct, a * c + b * ct);
    r = (rs * rs + rp * rp + (64'd1 << 17)) >> 18;
    if (r > 32768) r = 32768;
    refl_q.push_back(r[15:0]);
    tir_q.push_back(1'b0);
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Compare one accepted result with the oldest prediction.
  task check_result(logic [15:0] refl, logic tir);
    logic [15:0] exp_r;
    logic        exp_t;
    if (refl_q.size() == 0) begin
      report($sformatf("unexpected result %0d/%0b", refl, tir));
      return;
    end
    exp_r = refl_q.pop_front();
    exp_t = tir_q.pop_front();
    checked++;
    if (exp_t) tir_seen++;
    if (refl !== exp_r) report($sformatf("reflectance %0d, expected %0d", refl, exp_r));
    if (tir !== exp_t) report($sformatf("total_internal %0b, expected %0b", tir, exp_t));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] incident_x = '0, incident_y = '0, incident_z = '0;
  logic [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic [15:0] refr_index = 16'd4096;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] reflectance;
  logic        total_internal;

  reflectance_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int sent = 0;

  fresnel_reflectance u_dut (.*);

  always #5 clk = ~clk;

  // Offer one ray; held steady until the transfer happens.
  // Valid stays up on return; a drain, or an idle pause in the next call, drops it.
  task send_ray(logic [15:0] ix, iy, iz, nx, ny, nz, idx);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    incident_x <= ix; incident_y <= iy; incident_z <= iz;
    normal_x <= nx; normal_y <= ny; normal_z <= nz;
    refr_index <= idx;
    do @(posedge clk); while (in_stall);
    board.note_ray(ix, iy, iz, nx, ny, nz, idx);
    sent++;
    @(negedge clk);
  endtask

  // Random ray: mostly components within the unit range, some raw noise.
  task send_random();
    logic [15:0] v[6];
    logic [15:0] idx;
    int mode;
    mode = $urandom_range(9);
    foreach (v[k]) begin
      if (mode < 7) v[k] = 16'($signed($urandom_range(32768)) - 16384);
      else v[k] = 16'($urandom);
    end
    case ($urandom_range(5))
      0: idx = 16'($urandom);
      1: idx = 16'($urandom_range(1024, 4096));
      2: idx = 16'($urandom_range(4096, 8192));
      default: idx = 16'($urandom_range(4096, 7000));
    endcase
    send_ray(v[0], v[1], v[2], v[3], v[4], v[5], idx);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (board.refl_q.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(reflectance, total_internal);
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: normal incidence, grazing, extremes, zero index, total reflection.
    send_ray(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'd6144);
    send_ray(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'd6144);
    send_ray(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'd6144);
    send_ray(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'd2048);
    send_ray(16'h2D41, 16'h0000, 16'h2D41, 16'h0000, 16'h0000, 16'h4000, 16'd6144);
    send_ray(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000, 16'h0000, 16'h4000, 16'd6144);
    send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_ray(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_ray(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd1024);
    send_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd4096);
    send_ray(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_ray(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'hFFFF);
    send_ray(16'h3000, 16'h0000, 16'h2000, 16'h0000, 16'h0000, 16'h4000, 16'd4096);
    send_ray(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001, 16'h8000);
    send_ray(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_ray(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

    // Long receiver hold-off while rays keep coming, so the input backs up.
    hold_cycles = 300;
    repeat (120) send_random();
    wait_drained();

    send_idle_pct = 25; recv_idle_pct = 77;
    repeat (250) send_random();
    send_idle_pct = 77; recv_idle_pct = 25;
    repeat (200) send_random();
    // sender pauses until every result is back
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (170) send_random();

    fork
      wait_drained();
      begin
        #1_500_000;
      end
    join_any
    disable fork;
    repeat (100) @(negedge clk);

    $display("Sent %0d rays, checked %0d results, %0d with total internal reflection.",
             sent, board.checked, board.tir_seen);
    $display("Covered stalls from both sides, a long output hold-off and a full drain.");
    if (board.errors == 0 && board.refl_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ fresnel_reflectance.f @@
hw/rtl/frl_pkg.sv
hw/rtl/frl_div_pipe.sv
hw/rtl/frl_sqrt_pipe.sv
hw/rtl/fresnel_reflectance.sv
test/testbench.sv
